/* hdl/sht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table package
// Operation and status codes, field widths and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package sht_pkg;

  // Field widths of the request and result channels.
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SCAN   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // Register the request and issue table and stack reads.
    logic scan_start;  // Reset the scan index and the pending result.
    logic exec;        // Commit add, remove or get and load its result.
    logic scan_rd;     // Read the table entry at the scan index.
    logic scan_chk;    // Evaluate the scanned entry and advance.
    logic scan_end;    // Load the closing result of a scan.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // The output register can take a result this cycle.
    logic rd_nonzero;  // The entry just read holds a non-zero value.
    logic pend_vld;    // A scan result is held back waiting for its successor.
    logic scan_last;   // The scan index points at the highest slot.
  } dp_sts_t;

endpackage

/* hdl/sht_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table request channel
// Valid/ready channel that carries one operation request.
// ----------------------------------------------------------------------------
interface sht_req_if;
  import sht_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLOT_W-1:0]  slot_id;
  logic [VALUE_W-1:0] object_value;

  modport source (output valid, output op, output slot_id, output object_value,
                  input ready);
  modport sink (input valid, input op, input slot_id, input object_value,
                output ready);
endinterface

/* hdl/sht_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table result channel
// Valid/ready channel that carries one result of an operation.
// ----------------------------------------------------------------------------
interface sht_rsp_if;
  import sht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   out_slot;
  logic [VALUE_W-1:0]  out_value;
  logic                last;

  modport source (output valid, output status, output out_slot, output out_value,
                  output last, input ready);
  modport sink (input valid, input status, input out_slot, input out_value,
                input last, output ready);
endinterface

/* hdl/sht_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table controller
// Sequences one request at a time: a two-step read/commit for add, remove and
// get, and a slot-by-slot sweep for scan.
// ----------------------------------------------------------------------------
module sht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_op,
  output logic                req_ready,
  input  sht_pkg::dp_sts_t    sts,
  output sht_pkg::dp_cmd_t    cmd
);
  import sht_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_EXEC     = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_SCAN_END = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_blocked;

  // A scan hit with a held result must push that result out first.
  assign emit_blocked = sts.rd_nonzero && sts.pend_vld && !sts.out_free;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (op_e'(req_op) == OP_SCAN) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN_RD;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!emit_blocked) begin
          cmd.scan_chk = 1'b1;
          state_next   = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (sts.out_free) begin
          cmd.scan_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/sht_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table datapath
// Value table, in-use marks, free slot stack with its count, scan sweep
// registers and the output result register.
// ----------------------------------------------------------------------------
module sht_dpath #(
  parameter int SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sht_pkg::dp_cmd_t                cmd,
  output sht_pkg::dp_sts_t                sts,
  input  logic [1:0]                      req_op,
  input  logic [5:0]                      req_slot_id,
  input  logic [31:0]                     req_object_value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [1:0]                      rsp_status,
  output logic [5:0]                      rsp_out_slot,
  output logic [31:0]                     rsp_out_value,
  output logic                            rsp_last
);
  import sht_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0]     FULL_CNT  = CW'(SLOTS);
  localparam logic [IW-1:0]     LAST_IDX  = IW'(SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(SLOTS);

  // Storage.
  logic [VALUE_W-1:0] tbl_mem [SLOTS];
  logic [SLOTS-1:0]   in_use;
  logic [IW-1:0]      stk_mem [SLOTS];
  logic [SLOTS-1:0]   stk_wr;
  logic [CW-1:0]      fcnt;

  // Registered request.
  op_e                op_q;
  logic [IW-1:0]      sid_q;
  logic               sid_ok_q;
  logic [VALUE_W-1:0] obj_q;

  // Registered read data.
  logic [VALUE_W-1:0] tbl_q;
  logic               tbl_vld_q;
  logic [IW-1:0]      stk_q;
  logic               stk_vld_q;
  logic [IW-1:0]      stk_a_q;

  // Scan state.
  logic [IW-1:0]      scan_idx;
  logic               pend_vld;
  logic [IW-1:0]      pend_slot;
  logic [VALUE_W-1:0] pend_value;

  logic [IW-1:0]      rd_addr;
  logic               rd_en;
  logic [IW-1:0]      stk_addr;
  logic [IW-1:0]      pop_slot;
  logic               add_ok;
  logic               rem_ok;
  logic               rd_nz;
  logic               emit_pend;
  logic               load;
  status_e            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [VALUE_W-1:0] res_value;
  logic               res_last;

  // Read addressing: the request slot on accept, the sweep index during scan.
  assign rd_addr  = cmd.scan_rd ? scan_idx : req_slot_id[IW-1:0];
  assign rd_en    = cmd.accept || cmd.scan_rd;
  assign stk_addr = IW'(fcnt - CW'(1));

  // An entry that was never written since reset holds its reset value.
  assign pop_slot = stk_vld_q ? stk_q : stk_a_q;
  assign add_ok   = (fcnt != '0);
  assign rem_ok   = sid_ok_q && tbl_vld_q && (fcnt < FULL_CNT);
  assign rd_nz    = tbl_vld_q && (tbl_q != '0);

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= op_e'(req_op);
      sid_q    <= req_slot_id[IW-1:0];
      sid_ok_q <= ({1'b0, req_slot_id} < SLOTS_EXT);
      obj_q    <= req_object_value;
    end
  end

  // Table read port; the in-use mark masks entries not written since reset.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tbl_q     <= tbl_mem[rd_addr];
      tbl_vld_q <= in_use[rd_addr];
    end
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_q == OP_ADD && add_ok) begin
      tbl_mem[pop_slot] <= obj_q;
    end
  end

  // In-use marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (cmd.exec) begin
      if (op_q == OP_ADD && add_ok) begin
        in_use[pop_slot] <= 1'b1;
      end else if (op_q == OP_REMOVE && rem_ok) begin
        in_use[sid_q] <= 1'b0;
      end
    end
  end

  // Free stack read port: the top entry is fetched on accept.
  always_ff @(posedge clk) begin
    if (cmd.accept && add_ok) begin
      stk_q     <= stk_mem[stk_addr];
      stk_vld_q <= stk_wr[stk_addr];
      stk_a_q   <= stk_addr;
    end
  end

  // Free stack write port: a removed slot is pushed on top.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_q == OP_REMOVE && rem_ok) begin
      stk_mem[fcnt[IW-1:0]] <= sid_q;
    end
  end

  // Stack written marks and free count.
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_wr <= '0;
      fcnt   <= FULL_CNT;
    end else if (cmd.exec) begin
      if (op_q == OP_ADD && add_ok) begin
        fcnt <= fcnt - CW'(1);
      end else if (op_q == OP_REMOVE && rem_ok) begin
        stk_wr[fcnt[IW-1:0]] <= 1'b1;
        fcnt                 <= fcnt + CW'(1);
      end
    end
  end

  // Scan sweep. A hit is held until the next hit or the end of the sweep,
  // which tells whether it is the final result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      pend_vld <= 1'b0;
    end else if (cmd.scan_chk && rd_nz) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_chk) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (cmd.scan_chk && rd_nz) begin
      pend_slot  <= scan_idx;
      pend_value <= tbl_q;
    end
  end

  assign emit_pend = cmd.scan_chk && rd_nz && pend_vld;
  assign load      = cmd.exec || cmd.scan_end || emit_pend;

  // Result selection.
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_value  = '0;
    res_last   = 1'b1;
    if (emit_pend) begin
      res_slot  = SLOT_W'(pend_slot);
      res_value = pend_value;
      res_last  = 1'b0;
    end else if (cmd.scan_end) begin
      if (pend_vld) begin
        res_slot  = SLOT_W'(pend_slot);
        res_value = pend_value;
      end else begin
        res_status = ST_NONE;
      end
    end else begin
      case (op_q)
        OP_ADD: begin
          if (add_ok) begin
            res_slot = SLOT_W'(pop_slot);
          end else begin
            res_status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (!rem_ok) begin
            res_status = ST_NOT_USED;
          end
        end
        OP_GET: begin
          if (sid_ok_q) begin
            res_value = tbl_vld_q ? tbl_q : '0;
          end else begin
            res_status = ST_NOT_USED;
          end
        end
        default: begin
          res_status = ST_NONE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status    <= res_status;
      rsp_out_slot  <= res_slot;
      rsp_out_value <= res_value;
      rsp_last      <= res_last;
    end
  end

  // Status to the controller.
  assign sts.out_free   = !rsp_valid || rsp_ready;
  assign sts.rd_nonzero = rd_nz;
  assign sts.pend_vld   = pend_vld;
  assign sts.scan_last  = (scan_idx == LAST_IDX);

endmodule

/* hdl/slot_handle_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot handle table unit
// Handle allocator over SLOTS slots with a last-in first-out free list,
// value storage, lookup and an ordered scan of occupied non-zero slots.
// ----------------------------------------------------------------------------
// The unit handles one request at a time. Add, remove and get first
// register the request and read the value table and the free stack, then
// commit the update and load the result register. A scan reads the single
// table port once per slot and then checks the entry it read; a stalled
// result channel stretches the scan. Results sit in an output register, so
// the next request is taken while the previous result is still waiting. The
// table and stack are valid right after reset, with no clearing pass. The
// first add after reset returns slot SLOTS-1, and a removed slot is the next
// one handed out. A scan that finds no non-zero value returns a single
// "nothing found" result.
// ----------------------------------------------------------------------------
module slot_handle_table_unit #(
  parameter int SLOTS = 64
) (
  input logic       clk,
  input logic       rst,
  sht_req_if.sink   req,
  sht_rsp_if.source rsp
);
  import sht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sht_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_op           (req.op),
    .req_slot_id      (req.slot_id),
    .req_object_value (req.object_value),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_out_slot     (rsp.out_slot),
    .rsp_out_value    (rsp.out_value),
    .rsp_last         (rsp.last)
  );

  // A result is never loaded over one that has not been taken.
  a_load_free : assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.scan_end) |-> sts.out_free)
    else $error("result loaded while output register busy");

  // A held scan hit is only released when the output register can take it.
  a_scan_emit_free : assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_chk && sts.rd_nonzero && sts.pend_vld) |-> sts.out_free)
    else $error("scan result released while output register busy");

  // After committing a request the unit is ready for the next one.
  a_exec_ready : assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> req.ready)
    else $error("unit not ready after committing a request");

endmodule
